// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, quiet during reset.
`define MTAD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, quiet during reset.
`define MTAD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mtad_pkg.sv =====
// Package for the multiturn angle search: widths, lane type and register codes.
package mtad_pkg;

   // search sizing
   localparam int MAX_TURNS  = 64;
   localparam int ANGLE_BITS = 16;
   localparam int TURN_BITS  = (MAX_TURNS > 1) ? $clog2(MAX_TURNS) : 1;

   // fixed field widths
   localparam int FIELD_ANGLE_BITS = 16;
   localparam int FULL_TURNS_BITS  = 6;
   localparam int ERROR_BITS       = 16;
   localparam int COUNT_BITS       = 7;
   localparam int INV_RATIO_BITS   = 16;
   localparam int RATIO_BITS       = 24;
   localparam int FRAC_BITS        = 16;
   localparam int PROD_BITS        = ANGLE_BITS + RATIO_BITS;
   localparam int CNT_CMP_BITS     = COUNT_BITS + TURN_BITS + 1;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = RATIO_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEARCH_MODE = 2'd0,
      CSR_TURNS_COUNT = 2'd1,
      CSR_INV_RATIO   = 2'd2,
      CSR_GEAR_RATIO  = 2'd3
   } csr_index_type;

   // search mode codes
   localparam logic MODE_OFF_AXIS = 1'b0;
   localparam logic MODE_VERNIER  = 1'b1;

   // one item as it moves down the cell row
   typedef struct packed {
      logic                  valid;
      logic                  ok;
      logic                  mode;
      logic [TURN_BITS-1:0]  last_k;
      logic [ANGLE_BITS-1:0] secondary;
      logic [ANGLE_BITS-1:0] acc;
      logic [TURN_BITS-1:0]  best_k;
      logic [ANGLE_BITS-1:0] best_err;
   } lane_type;

endpackage

// ===== rtl/mtad_front.sv =====
// Front stages: scale the motor angle by the ratio and round to the base prediction.
module mtad_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic [mtad_pkg::ANGLE_BITS-1:0]     primary,
   input  logic [mtad_pkg::ANGLE_BITS-1:0]     secondary,
   input  logic                                ok,
   input  logic                                mode,
   input  logic [mtad_pkg::RATIO_BITS-1:0]     ratio,
   input  logic [mtad_pkg::TURN_BITS-1:0]      last_k,
   output mtad_pkg::lane_type                  lane_out
);

   localparam int SUM_BITS = mtad_pkg::PROD_BITS + 1;
   localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) << (mtad_pkg::FRAC_BITS - 1);

   logic                               a_valid_ff, a_valid_in;
   logic                               a_ok_ff;
   logic                               a_mode_ff;
   logic [mtad_pkg::TURN_BITS-1:0]     a_last_ff;
   logic [mtad_pkg::ANGLE_BITS-1:0]    a_sec_ff;
   logic [mtad_pkg::PROD_BITS-1:0]     a_prod_ff, a_prod_in;
   logic [SUM_BITS-1:0]                rounded;
   mtad_pkg::lane_type                 b_lane_ff, b_lane_in;

   // stage A: one multiply
   assign a_valid_in = in_valid;
   assign a_prod_in  = mtad_pkg::PROD_BITS'(primary) * mtad_pkg::PROD_BITS'(ratio);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ok_ff   <= ok;
         a_mode_ff <= mode;
         a_last_ff <= last_k;
         a_sec_ff  <= secondary;
         a_prod_ff <= a_prod_in;
      end
   end

   // stage B: round, drop the fraction, wrap to one turn
   assign rounded = SUM_BITS'(a_prod_ff) + ROUND_HALF;

   always_comb begin
      b_lane_in           = '0;
      b_lane_in.valid     = a_valid_ff;
      b_lane_in.ok        = a_ok_ff;
      b_lane_in.mode      = a_mode_ff;
      b_lane_in.last_k    = a_last_ff;
      b_lane_in.secondary = a_sec_ff;
      b_lane_in.acc       = rounded[mtad_pkg::FRAC_BITS +: mtad_pkg::ANGLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_lane_ff.valid <= 1'b0;
      end else if (advance) begin
         b_lane_ff.valid <= b_lane_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_lane_ff.ok        <= b_lane_in.ok;
         b_lane_ff.mode      <= b_lane_in.mode;
         b_lane_ff.last_k    <= b_lane_in.last_k;
         b_lane_ff.secondary <= b_lane_in.secondary;
         b_lane_ff.acc       <= b_lane_in.acc;
         b_lane_ff.best_k    <= b_lane_in.best_k;
         b_lane_ff.best_err  <= b_lane_in.best_err;
      end
   end

   assign lane_out = b_lane_ff;

endmodule

// ===== rtl/mtad_cell.sv =====
// One search cell: tests one turn count and keeps the running best.
module mtad_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [mtad_pkg::TURN_BITS-1:0]      cell_idx,
   input  logic [mtad_pkg::ANGLE_BITS-1:0]     step,
   input  mtad_pkg::lane_type                  lane_in,
   output mtad_pkg::lane_type                  lane_out
);

   logic [mtad_pkg::ANGLE_BITS-1:0] pred;
   logic [mtad_pkg::ANGLE_BITS-1:0] diff;
   logic [mtad_pkg::ANGLE_BITS-1:0] err;
   logic                            first;
   logic                            in_range;
   logic                            take;
   mtad_pkg::lane_type              lane_ff, lane_in_nx;

   // predicted angle and shortest wrapped distance
   assign pred     = (lane_in.mode == mtad_pkg::MODE_VERNIER) ? (-lane_in.acc) : lane_in.acc;
   assign diff     = pred - lane_in.secondary;
   assign err      = diff[mtad_pkg::ANGLE_BITS-1] ? (-diff) : diff;
   assign first    = (cell_idx == '0);
   assign in_range = (cell_idx <= lane_in.last_k);
   assign take     = first || (in_range && (err < lane_in.best_err));

   // update the best and step to the next turn
   always_comb begin
      lane_in_nx     = lane_in;
      lane_in_nx.acc = lane_in.acc + step;
      if (take) begin
         lane_in_nx.best_k   = cell_idx;
         lane_in_nx.best_err = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff.valid <= lane_in_nx.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff.ok        <= lane_in_nx.ok;
         lane_ff.mode      <= lane_in_nx.mode;
         lane_ff.last_k    <= lane_in_nx.last_k;
         lane_ff.secondary <= lane_in_nx.secondary;
         lane_ff.acc       <= lane_in_nx.acc;
         lane_ff.best_k    <= lane_in_nx.best_k;
         lane_ff.best_err  <= lane_in_nx.best_err;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== rtl/multiturn_angle_disambiguation_unit.sv =====
// Multiturn angle search: front scaling stages, a row of search cells, output register.
// An accepted item passes front stages A and B, the row of cells and the output register.
// Throughput: one item per cycle; a new item enters every cycle the output is not stalled.
// The row of MAX_TURNS cells, one per turn candidate, sets the latency.
// Reset: synchronous, active high; clears all valid flags and loads the register defaults.
`include "assert_macros.svh"

module multiturn_angle_disambiguation_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   // input items
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [mtad_pkg::FIELD_ANGLE_BITS-1:0]     req_primary_angle,
   input  logic [mtad_pkg::FIELD_ANGLE_BITS-1:0]     req_secondary_angle,
   input  logic                                      req_primary_ok,
   input  logic                                      req_secondary_ok,
   // result items
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [mtad_pkg::FULL_TURNS_BITS-1:0]      rsp_full_turns,
   output logic [mtad_pkg::ERROR_BITS-1:0]           rsp_best_error,
   output logic                                      rsp_turns_valid,
   // configuration writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [mtad_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [mtad_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   localparam int CMP = mtad_pkg::CNT_CMP_BITS;

   logic                                    mode_ff;
   logic [mtad_pkg::COUNT_BITS-1:0]         count_ff;
   logic [mtad_pkg::INV_RATIO_BITS-1:0]     inv_ratio_ff;
   logic [mtad_pkg::RATIO_BITS-1:0]         gear_ratio_ff;

   logic                                    advance;
   logic [mtad_pkg::RATIO_BITS-1:0]         ratio;
   logic [mtad_pkg::ANGLE_BITS-1:0]         step;
   logic [CMP-1:0]                          count_wide;
   logic [mtad_pkg::TURN_BITS-1:0]          last_k;

   mtad_pkg::lane_type                      chain [0:mtad_pkg::MAX_TURNS];

   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [mtad_pkg::FULL_TURNS_BITS-1:0]    rsp_turns_ff, rsp_turns_in;
   logic [mtad_pkg::ERROR_BITS-1:0]         rsp_err_ff, rsp_err_in;
   logic                                    rsp_ok_ff, rsp_ok_in;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= mtad_pkg::MODE_OFF_AXIS;
         count_ff      <= mtad_pkg::COUNT_BITS'(1);
         inv_ratio_ff  <= '1;
         gear_ratio_ff <= mtad_pkg::RATIO_BITS'(65536);
      end else if (csr_valid && csr_ready) begin
         unique case (mtad_pkg::csr_index_type'(csr_index))
            mtad_pkg::CSR_SEARCH_MODE: begin
               mode_ff <= csr_data[0];
            end
            mtad_pkg::CSR_TURNS_COUNT: begin
               count_ff <= csr_data[mtad_pkg::COUNT_BITS-1:0];
            end
            mtad_pkg::CSR_INV_RATIO: begin
               inv_ratio_ff <= csr_data[mtad_pkg::INV_RATIO_BITS-1:0];
            end
            mtad_pkg::CSR_GEAR_RATIO: begin
               gear_ratio_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // derived search settings: ratio, per-turn step, last candidate
   assign ratio = (mode_ff == mtad_pkg::MODE_VERNIER) ? gear_ratio_ff
                                                      : mtad_pkg::RATIO_BITS'(inv_ratio_ff);
   assign step       = ratio[mtad_pkg::ANGLE_BITS-1:0];
   assign count_wide = CMP'(count_ff);

   always_comb begin
      if (count_wide == '0) begin
         last_k = '0;
      end else if (count_wide > CMP'(mtad_pkg::MAX_TURNS)) begin
         last_k = mtad_pkg::TURN_BITS'(mtad_pkg::MAX_TURNS - 1);
      end else begin
         last_k = mtad_pkg::TURN_BITS'(count_wide - CMP'(1));
      end
   end

   // whole row moves together unless a result is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   mtad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .primary   (mtad_pkg::ANGLE_BITS'(req_primary_angle)),
      .secondary (mtad_pkg::ANGLE_BITS'(req_secondary_angle)),
      .ok        (req_primary_ok && req_secondary_ok),
      .mode      (mode_ff),
      .ratio     (ratio),
      .last_k    (last_k),
      .lane_out  (chain[0])
   );

   // one cell per turn candidate
   for (genvar i = 0; i < mtad_pkg::MAX_TURNS; i++) begin : g_cell
      mtad_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (mtad_pkg::TURN_BITS'(i)),
         .step     (step),
         .lane_in  (chain[i]),
         .lane_out (chain[i+1])
      );
   end

   // output register; invalid angles report zeros
   assign rsp_valid_in = chain[mtad_pkg::MAX_TURNS].valid;
   assign rsp_ok_in    = chain[mtad_pkg::MAX_TURNS].ok;
   assign rsp_turns_in = rsp_ok_in
                       ? mtad_pkg::FULL_TURNS_BITS'(chain[mtad_pkg::MAX_TURNS].best_k) : '0;
   assign rsp_err_in   = rsp_ok_in
                       ? mtad_pkg::ERROR_BITS'(chain[mtad_pkg::MAX_TURNS].best_err) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_turns_ff <= rsp_turns_in;
         rsp_err_ff   <= rsp_err_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_full_turns  = rsp_turns_ff;
   assign rsp_best_error  = rsp_err_ff;
   assign rsp_turns_valid = rsp_ok_ff;

   // checks
   `MTAD_ASSERT_IMP(a_invalid_zero, rsp_valid && !rsp_turns_valid,
      (rsp_full_turns == '0) && (rsp_best_error == '0), "invalid item has nonzero result")
   `MTAD_ASSERT_IMP(a_err_half, rsp_valid && rsp_turns_valid,
      rsp_best_error <= mtad_pkg::ERROR_BITS'(1 << (mtad_pkg::ANGLE_BITS - 1)),
      "best error above half a turn")
   `MTAD_ASSERT_IMP(a_turns_range, rsp_valid && rsp_turns_valid,
      mtad_pkg::TURN_BITS'(rsp_full_turns) <= last_k, "chosen turn beyond candidate count")
   `MTAD_ASSERT_NEXT(a_row_hold, rsp_valid && rsp_stall,
      $stable(chain[mtad_pkg::MAX_TURNS]), "cell row moved while result held")

endmodule
